FILE: sv/splrc_pkg.sv
// ----------------------------------------------------------------------------
// splrc_pkg
// Types and constants shared by the sampler pad loop region control block.
// ----------------------------------------------------------------------------
`default_nettype none

package splrc_pkg;

  // Field widths
  localparam int unsigned FrameW = 24;
  localparam int unsigned IdW    = 4;
  localparam int unsigned LenW   = 13;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CountW = 4;

  // Largest frame value, also the reset length of the sample
  localparam logic [FrameW-1:0] FrameMax = {FrameW{1'b1}};

  // Depth of the queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  // Configuration register indexes
  localparam logic CfgSticky = 1'b0;
  localparam logic CfgTotal  = 1'b1;

  // Command codes on the input stream
  typedef enum logic [CmdW-1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_e;

  // Work kinds after classification
  typedef enum logic [1:0] {
    K_PRESS   = 2'd0,
    K_RELEASE = 2'd1,
    K_TICK    = 2'd2,
    K_NOP     = 2'd3
  } kind_e;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_WALK    = 3'd1,
    ST_EDIT    = 3'd2,
    ST_REFRESH = 3'd3,
    ST_TICK    = 3'd4,
    ST_DONE    = 3'd5
  } state_e;

  // One classified request
  typedef struct packed {
    kind_e             kind;
    logic [IdW-1:0]    pad_id;
    logic [FrameW-1:0] pad_start;
    logic [FrameW-1:0] pad_end;
    logic [LenW-1:0]   block_frames;
  } item_t;

  // One result
  typedef struct packed {
    logic              playing;
    logic [FrameW-1:0] play_frame;
    logic [FrameW-1:0] loop_start;
    logic [FrameW-1:0] loop_end;
    logic              looping;
    logic [CountW-1:0] held_count;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/splrc_front.sv
// ----------------------------------------------------------------------------
// splrc_front
// Accepts stream requests, classifies the command and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module splrc_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 sticky_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [71:0]          s_axis_tdata,  // pad_id, pad_start, pad_end, block_frames
  input  wire logic [1:0]           s_axis_tuser,  // cmd
  output logic                      item_valid_o,
  input  wire logic                 item_ready_i,
  output splrc_pkg::item_t          item_o
);
  import splrc_pkg::*;

  item_t            fifo_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCw-1:0]   count_q, count_d;
  item_t            in_item;
  logic             push, pop;

  // Classify the command; releases are dropped in sticky mode
  always_comb begin
    in_item.pad_id       = s_axis_tdata[3:0];
    in_item.pad_start    = s_axis_tdata[27:4];
    in_item.pad_end      = s_axis_tdata[51:28];
    in_item.block_frames = s_axis_tdata[64:52];
    unique case (cmd_e'(s_axis_tuser))
      CMD_PRESS:   in_item.kind = K_PRESS;
      CMD_RELEASE: in_item.kind = sticky_i ? K_NOP : K_RELEASE;
      CMD_TICK:    in_item.kind = K_TICK;
      default:     in_item.kind = K_NOP;
    endcase
  end

  assign s_axis_tready = (count_q != QCw'(QDepth));
  assign item_valid_o  = (count_q != '0);
  assign item_o        = fifo_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = item_valid_o && item_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QAw'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QAw'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + QCw'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCw'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold queued requests
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: sv/splrc_back.sv
// ----------------------------------------------------------------------------
// splrc_back
// Sequencer that keeps the sorted held-pad list and the voice state.
// ----------------------------------------------------------------------------
`default_nettype none

module splrc_back #(
  parameter int unsigned MAX_HELD = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        sticky_i,
  input  wire logic [splrc_pkg::FrameW-1:0] total_frames_i,
  input  wire logic                        item_valid_i,
  output logic                             item_ready_o,
  input  wire splrc_pkg::item_t            item_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output splrc_pkg::result_t               res_o
);
  import splrc_pkg::*;

  localparam int unsigned Cw = $clog2(MAX_HELD + 1);
  localparam int unsigned Aw = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;

  state_e            state_q, state_d;
  item_t             item_q, item_d;
  logic              was_empty_q, was_empty_d;
  logic [FrameW-1:0] old_front_q, old_front_d;
  logic [Cw-1:0]     idx_q, idx_d;
  logic              dup_q, dup_d;
  logic [Cw-1:0]     total_q, total_d;
  logic              playing_q, playing_d;
  logic              looping_q, looping_d;
  logic              pad_down_q, pad_down_d;
  logic [FrameW-1:0] act_start_q, act_start_d;
  logic [FrameW-1:0] pend_start_q, pend_start_d;
  logic [FrameW-1:0] act_end_q, act_end_d;
  logic [FrameW-1:0] read_q, read_d;

  // Held list, kept in order of start frame
  logic [IdW-1:0]    ids_q    [MAX_HELD];
  logic [FrameW-1:0] starts_q [MAX_HELD];
  logic [FrameW-1:0] ends_q   [MAX_HELD];
  logic [IdW-1:0]    ids_up   [MAX_HELD];
  logic [FrameW-1:0] starts_up[MAX_HELD];
  logic [FrameW-1:0] ends_up  [MAX_HELD];
  logic [IdW-1:0]    ids_dn   [MAX_HELD];
  logic [FrameW-1:0] starts_dn[MAX_HELD];
  logic [FrameW-1:0] ends_dn  [MAX_HELD];

  logic [Aw-1:0]     rd_addr;
  logic [Cw-1:0]     total_m1;
  logic [IdW-1:0]    rd_id;
  logic [FrameW-1:0] rd_start;
  logic [FrameW-1:0] rd_end;
  logic              at_end;
  logic              is_press;
  logic              full;
  logic              do_insert, do_remove;
  logic [FrameW-1:0] front_start;
  logic              ask_play;
  logic [FrameW-1:0] tk_read;
  logic              tk_playing;
  logic [FrameW:0]   tk_sum;
  logic [Cw+3:0]     count_ext;

  // Neighbour taps for shifting entries up or down
  for (genvar g = 0; g < MAX_HELD; g++) begin : g_tap
    if (g > 0) begin : g_up
      assign ids_up[g]    = ids_q[g-1];
      assign starts_up[g] = starts_q[g-1];
      assign ends_up[g]   = ends_q[g-1];
    end else begin : g_up0
      assign ids_up[g]    = ids_q[g];
      assign starts_up[g] = starts_q[g];
      assign ends_up[g]   = ends_q[g];
    end
    if (g < MAX_HELD - 1) begin : g_dn
      assign ids_dn[g]    = ids_q[g+1];
      assign starts_dn[g] = starts_q[g+1];
      assign ends_dn[g]   = ends_q[g+1];
    end else begin : g_dnl
      assign ids_dn[g]    = ids_q[g];
      assign starts_dn[g] = starts_q[g];
      assign ends_dn[g]   = ends_q[g];
    end
  end

  // Read port: walk index, or the last entry while refreshing; entry 0 is tapped apart
  assign total_m1    = total_q - Cw'(1);
  assign rd_addr     = (state_q == ST_REFRESH) ? total_m1[Aw-1:0] : idx_q[Aw-1:0];
  assign rd_id       = ids_q[rd_addr];
  assign rd_start    = starts_q[rd_addr];
  assign rd_end      = ends_q[rd_addr];
  assign front_start = starts_q[0];

  assign at_end    = (idx_q == total_q);
  assign is_press  = (item_q.kind == K_PRESS);
  assign full      = (total_q >= Cw'(MAX_HELD));
  assign do_insert = (state_q == ST_EDIT) && !dup_q && !full;
  assign do_remove = (state_q == ST_EDIT) && dup_q && !(is_press && !sticky_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          unique case (item_i.kind)
            K_PRESS, K_RELEASE: state_d = ST_WALK;
            K_TICK:             state_d = ST_TICK;
            default:            state_d = ST_DONE;
          endcase
        end
      end
      ST_WALK: begin
        if (at_end) begin
          state_d = is_press ? ST_EDIT : ST_REFRESH;
        end else if ((is_press && (rd_start > item_q.pad_start)) ||
                     (rd_id == item_q.pad_id)) begin
          state_d = ST_EDIT;
        end
      end
      ST_EDIT: begin
        if (dup_q) begin
          state_d = (is_press && !sticky_i) ? ST_DONE : ST_REFRESH;
        end else begin
          state_d = full ? ST_DONE : ST_REFRESH;
        end
      end
      ST_REFRESH: state_d = ST_DONE;
      ST_TICK:    state_d = ST_DONE;
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    item_ready_o = (state_q == ST_IDLE);
    res_valid_o  = (state_q == ST_DONE);
  end

  // Tick: loop back or stop at the end, then advance by one block while still playing
  always_comb begin
    tk_read    = read_q;
    tk_playing = playing_q;
    if (read_q >= act_end_q) begin
      if ((act_start_q == act_end_q) || !pad_down_q) begin
        tk_playing = 1'b0;
        tk_read    = total_frames_i;
      end else if (pend_start_q <= total_frames_i) begin
        tk_read = pend_start_q;
      end
    end
    tk_sum = {1'b0, tk_read} + {{(FrameW + 1 - LenW){1'b0}}, item_q.block_frames};
  end

  // A new front start asks for playback when the pending start is live
  assign ask_play = is_press && (was_empty_q || (front_start != old_front_q)) &&
                    (!looping_q || !playing_q || (act_start_q == front_start));

  // Datapath next values
  always_comb begin
    item_d       = item_q;
    was_empty_d  = was_empty_q;
    old_front_d  = old_front_q;
    idx_d        = idx_q;
    dup_d        = dup_q;
    total_d      = total_q;
    playing_d    = playing_q;
    looping_d    = looping_q;
    pad_down_d   = pad_down_q;
    act_start_d  = act_start_q;
    pend_start_d = pend_start_q;
    act_end_d    = act_end_q;
    read_d       = read_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_d      = item_i;
          was_empty_d = (total_q == '0);
          old_front_d = front_start;
          idx_d       = '0;
          dup_d       = 1'b0;
        end
      end
      ST_WALK: begin
        if (!at_end) begin
          if (is_press && (rd_start > item_q.pad_start)) begin
            dup_d = 1'b0;
          end else if (rd_id == item_q.pad_id) begin
            dup_d = 1'b1;
          end else begin
            idx_d = idx_q + Cw'(1);
          end
        end
      end
      ST_EDIT: begin
        if (do_insert) begin
          total_d = total_q + Cw'(1);
        end else if (do_remove) begin
          total_d = total_m1;
        end
      end
      ST_REFRESH: begin
        if (total_q != '0) begin
          if (!looping_q || !playing_q) begin
            act_start_d = front_start;
          end
          pend_start_d = front_start;
          act_end_d    = rd_end;
          if (ask_play) begin
            playing_d = 1'b1;
            if (front_start <= total_frames_i) begin
              read_d = front_start;
            end
          end
        end
        if (is_press) begin
          pad_down_d = 1'b1;
        end else if (total_q == '0) begin
          pad_down_d = 1'b0;
        end
      end
      ST_TICK: begin
        looping_d = pad_down_q;
        playing_d = tk_playing;
        if (read_q >= act_end_q) begin
          if ((act_start_q == act_end_q) || !pad_down_q) begin
            act_start_d  = '0;
            pend_start_d = '0;
            act_end_d    = total_frames_i;
          end else begin
            act_start_d = pend_start_q;
          end
        end
        if (tk_playing) begin
          read_d = (tk_sum > {1'b0, total_frames_i}) ? total_frames_i : tk_sum[FrameW-1:0];
        end else begin
          read_d = tk_read;
        end
      end
      default: begin
      end
    endcase
  end

  // Control and voice state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      total_q      <= '0;
      playing_q    <= 1'b0;
      looping_q    <= 1'b0;
      pad_down_q   <= 1'b0;
      act_start_q  <= '0;
      pend_start_q <= '0;
      act_end_q    <= FrameMax;
      read_q       <= '0;
      idx_q        <= '0;
      dup_q        <= 1'b0;
      was_empty_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      total_q      <= total_d;
      playing_q    <= playing_d;
      looping_q    <= looping_d;
      pad_down_q   <= pad_down_d;
      act_start_q  <= act_start_d;
      pend_start_q <= pend_start_d;
      act_end_q    <= act_end_d;
      read_q       <= read_d;
      idx_q        <= idx_d;
      dup_q        <= dup_d;
      was_empty_q  <= was_empty_d;
    end
  end

  // Latched request payload
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    old_front_q <= old_front_d;
  end

  // Shift entries to open or close a slot
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_HELD; i++) begin
      if (do_insert) begin
        if (Cw'(i) == idx_q) begin
          ids_q[i]    <= item_q.pad_id;
          starts_q[i] <= item_q.pad_start;
          ends_q[i]   <= item_q.pad_end;
        end else if ((Cw'(i) > idx_q) && (Cw'(i) <= total_q)) begin
          ids_q[i]    <= ids_up[i];
          starts_q[i] <= starts_up[i];
          ends_q[i]   <= ends_up[i];
        end
      end else if (do_remove) begin
        if ((Cw'(i) >= idx_q) && (Cw'(i) < total_m1)) begin
          ids_q[i]    <= ids_dn[i];
          starts_q[i] <= starts_dn[i];
          ends_q[i]   <= ends_dn[i];
        end
      end
    end
  end

  // Result from the state after the request
  assign count_ext = {4'b0, total_q};
  always_comb begin
    res_o.playing    = playing_q;
    res_o.play_frame = read_q;
    res_o.loop_start = act_start_q;
    res_o.loop_end   = act_end_q;
    res_o.looping    = looping_q;
    res_o.held_count = count_ext[CountW-1:0];
  end

endmodule

`default_nettype wire

FILE: sv/sampler_pad_loop_region_control.sv
// Sequencing: a tick runs through the tick state to the done state and the output register;
//   a press or release walks the list (reading one entry a cycle), then edits it and
//   refreshes as needed; a dropped request goes to done. The back sequencer works on one
//   request at a time while a 2-entry queue and the output register decouple.
// Reset (asynchronous, active low): empty list, voice stopped, loop end at
//   the largest frame, sticky mode off, sample length 16777215 frames.
// ----------------------------------------------------------------------------
// sampler_pad_loop_region_control
// Top level: configuration registers, front queue, back sequencer, output.
// ----------------------------------------------------------------------------
`default_nettype none

module sampler_pad_loop_region_control #(
  parameter int unsigned MAX_HELD = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // pad_id, pad_start, pad_end, block_frames
  input  wire logic [1:0]  s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,  // playing, play_frame, loop_start, loop_end,
                                          // looping, held_count
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);
  import splrc_pkg::*;

  logic              sticky_q;
  logic [FrameW-1:0] total_q;
  logic              item_valid, item_ready;
  item_t             item;
  logic              res_valid, res_ready;
  result_t           res;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sticky_q <= 1'b0;
      total_q  <= FrameMax;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgSticky: sticky_q <= cfg_data_i[0];
        CfgTotal:  total_q  <= cfg_data_i;
        default:   sticky_q <= sticky_q;
      endcase
    end
  end

  splrc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sticky_i     (sticky_q),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  splrc_back #(
    .MAX_HELD(MAX_HELD)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sticky_i      (sticky_q),
    .total_frames_i(total_q),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_i        (item),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // Output register: take a result when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.held_count, out_q.looping, out_q.loop_end,
                          out_q.loop_start, out_q.play_frame, out_q.playing};

endmodule

`default_nettype wire
